// ===== sv/dss_pkg.sv =====
// Shared types and constants for the drum step sequencer.
`default_nettype none
package dss_pkg;
  localparam logic [2:0] REQ_STEP    = 3'd0;
  localparam logic [2:0] REQ_CLOCK   = 3'd1;
  localparam logic [2:0] REQ_REST    = 3'd2;
  localparam logic [2:0] REQ_ACCENT  = 3'd3;
  localparam logic [2:0] REQ_NOTE    = 3'd4;
  localparam logic [2:0] REQ_SHIFT   = 3'd5;
  localparam logic [2:0] REQ_RELEASE = 3'd6;

  localparam logic [2:0] REG_GATE   = 3'd0;
  localparam logic [2:0] REG_NVEL   = 3'd1;
  localparam logic [2:0] REG_AVEL   = 3'd2;
  localparam logic [2:0] REG_TLEN   = 3'd3;
  localparam logic [2:0] REG_TOFF   = 3'd4;
  localparam logic [2:0] REG_MUTE   = 3'd5;

  localparam logic [7:0] GATE_IDLE = 8'hFF;
  localparam logic [6:0] NOTE_BASE = 7'd36;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_POS   = 5'b00010,
    ST_READ  = 5'b00100,
    ST_VOICE = 5'b01000,
    ST_NEXT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic       start;
    logic [6:0] len;
    logic [37:0] dividend;
  } mod_req_t;
endpackage
`default_nettype wire

// ===== sv/dss_mod.sv =====
// Iterative restoring modulo unit, one quotient bit per cycle.
`default_nettype none
module dss_mod
  import dss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire mod_req_t   req,
  output logic            done,
  output logic [6:0]      rem
);
  logic [37:0] dv_r, dv_nxt;
  logic [6:0]  rm_r, rm_nxt;
  logic [6:0]  ln_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r;
  logic [7:0]  trial;

  assign trial = {rm_r, dv_r[37]};
  always_comb begin
    dv_nxt = dv_r; rm_nxt = rm_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (req.start) begin
      dv_nxt = req.dividend; rm_nxt = '0; cnt_nxt = 6'd38; busy_nxt = 1'b1;
    end else if (busy_r) begin
      dv_nxt = {dv_r[36:0], 1'b0};
      if (trial >= {1'b0, ln_r}) rm_nxt = 7'(trial - {1'b0, ln_r});
      else rm_nxt = trial[6:0];
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
      done_r <= busy_r && (cnt_r == 6'd1);
    end
    dv_r <= dv_nxt; rm_r <= rm_nxt;
    if (req.start) ln_r <= req.len;
  end
  assign done = done_r;
  assign rem  = rm_r;

`ifndef SYNTH
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ln_r != '0) else $error("zero modulus");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> rem < ln_r) else $error("remainder too large");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("start lost");
`endif
endmodule
`default_nettype wire

// ===== sv/drum_step_sequencer.sv =====
// Top level: voice memories, register file and the request sequencer.
// Step tick: per unmuted track a modulo for the track position, then per voice a modulo for the step.
// Clock tick and release step each voice through READ, VOICE and NEXT; edits pass READ and VOICE.
// Events leave on out_valid for one cycle each; the receiver cannot stall.
// Reset is synchronous (rst_n low); voice state is restored by a sweep
// over all TRACKS*VOICES entries after reset, during which busy stays high.
`default_nettype none
module drum_step_sequencer
  import dss_pkg::*;
#(
  parameter int TRACKS = 2,
  parameter int VOICES = 16,
  parameter int STEPS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [31:0] in_tick,
  input  wire logic        in_track_sel,
  input  wire logic        in_all_tracks,
  input  wire logic [3:0]  in_voice_sel,
  input  wire logic [3:0]  in_step_index,
  input  wire logic        in_bit_value,
  input  wire logic [6:0]  in_note_value,
  input  wire logic [3:0]  in_voice_offset,
  input  wire logic [4:0]  in_voice_length,
  output logic             out_valid,
  output logic             out_event_kind,
  output logic [6:0]       out_note,
  output logic [6:0]       out_velocity,
  output logic [3:0]       out_channel,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = TW + VW;
  localparam int NV = TRACKS * VOICES;
  localparam int SW = $clog2(STEPS);

  // configuration
  logic [6:0] gate_len_r, nvel_r, avel_r;
  logic [4:0] tlen_r;
  logic [3:0] toff_r;
  logic [1:0] mute_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_len_r <= 7'd5; nvel_r <= 7'd100; avel_r <= 7'd127;
      tlen_r <= 5'd16; toff_r <= '0; mute_r <= '0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (cfg_idx)
        REG_GATE: gate_len_r <= pwdata[6:0];
        REG_NVEL: nvel_r     <= pwdata[6:0];
        REG_AVEL: avel_r     <= pwdata[6:0];
        REG_TLEN: tlen_r     <= pwdata[4:0];
        REG_TOFF: toff_r     <= pwdata[3:0];
        REG_MUTE: mute_r     <= pwdata[1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_idx)
      REG_GATE: prdata = {25'd0, gate_len_r};
      REG_NVEL: prdata = {25'd0, nvel_r};
      REG_AVEL: prdata = {25'd0, avel_r};
      REG_TLEN: prdata = {27'd0, tlen_r};
      REG_TOFF: prdata = {28'd0, toff_r};
      REG_MUTE: prdata = {30'd0, mute_r};
      default:  prdata = '0;
    endcase
  end

  // voice memory: {step, accent, note, shift, length, gate}
  localparam int MW = STEPS + STEPS + 7 + 4 + 5 + 8;
  logic [MW-1:0] mem [NV];
  logic [MW-1:0] rd_r, wr_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end
  logic [STEPS-1:0] m_step, m_acc;
  logic [6:0] m_note;
  logic [3:0] m_shift;
  logic [4:0] m_len;
  logic [7:0] m_gate;
  assign {m_step, m_acc, m_note, m_shift, m_len, m_gate} = rd_r;

  function automatic logic [6:0] clamp(input logic [4:0] l);
    if (l == 5'd0) return 7'd1;
    if (32'(l) > STEPS) return 7'(STEPS);
    return {2'b00, l};
  endfunction

  function automatic logic [STEPS-1:0] reset_steps();
    logic [STEPS-1:0] s;
    s = '0;
    for (int j = 0; j < STEPS; j += 4) s[j] = 1'b1;
    return s;
  endfunction

  state_t st_r, st_nxt;
  mod_req_t mreq;
  logic mdone;
  logic [6:0] mrem;
  dss_mod u_mod (.clk, .rst_n, .req(mreq), .done(mdone), .rem(mrem));

  logic [2:0]  req_r;
  logic [31:0] tick_r;
  logic        ts_r, all_r, bv_r;
  logic [3:0]  vs_r, si_r, vo_r;
  logic [6:0]  nv_r;
  logic [4:0]  vl_r;
  logic [TW-1:0] t_r, t_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic [AW:0] clr_r;
  logic        clearing;
  logic [6:0]  pos_r;
  logic        phase_r, phase_nxt;
  logic        pend_r, pend_nxt;
  logic [6:0]  pnote_r, pvel_r, pnote_nxt, pvel_nxt;
  logic        pkind_r, pkind_nxt;
  logic [3:0]  pch_r, pch_nxt;
  logic        sel_ok, lastv, lastt, trk_en;

  assign clearing = (clr_r != NV[AW:0]);
  assign busy     = (st_r != ST_IDLE) || clearing;
  assign sel_ok   = (32'(ts_r) < TRACKS) && (32'(vs_r) < VOICES);
  assign lastv    = (32'(v_r) == VOICES - 1);
  assign lastt    = (32'(t_r) == TRACKS - 1);
  assign trk_en   = (req_r == REQ_STEP) ? !(32'(t_r) < 2 && mute_r[t_r[0]] &&
                    (TW == 1 || t_r < TW'(2)))
                  : (all_r || 32'(t_r) == 32'(ts_r));

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_req_type; tick_r <= in_tick; ts_r <= in_track_sel;
      all_r <= in_all_tracks; vs_r <= in_voice_sel; si_r <= in_step_index;
      bv_r <= in_bit_value; nv_r <= in_note_value; vo_r <= in_voice_offset;
      vl_r <= in_voice_length;
    end
  end

  logic [AW-1:0] cur_addr;
  assign cur_addr = (req_r == REQ_STEP || req_r == REQ_CLOCK ||
                     req_r == REQ_RELEASE) ? {t_r, v_r} : {TW'(ts_r), VW'(vs_r)};

  always_comb begin
    st_nxt = st_r; t_nxt = t_r; v_nxt = v_r; phase_nxt = phase_r;
    pend_nxt = 1'b0; pnote_nxt = pnote_r; pvel_nxt = pvel_r;
    pkind_nxt = pkind_r; pch_nxt = pch_r;
    mreq = '0; wr_en = 1'b0; wr_addr = cur_addr; wr_data = rd_r;
    rd_addr = cur_addr;
    if (clearing) begin
      wr_en = 1'b1; wr_addr = clr_r[AW-1:0];
      wr_data = {(clr_r[VW-1:0] == '0) ? reset_steps() : {STEPS{1'b0}},
                 {STEPS{1'b0}}, 7'(NOTE_BASE + 7'(clr_r[VW-1:0])), 4'd0,
                 5'(STEPS), GATE_IDLE};
    end
    case (st_r)
      ST_IDLE: begin
        if (start && !busy) begin
          t_nxt = '0; v_nxt = '0; phase_nxt = 1'b0;
          st_nxt = (in_req_type == REQ_STEP) ? ST_POS : ST_READ;
        end
      end
      ST_POS: begin
        if (!trk_en) begin
          st_nxt = ST_NEXT; v_nxt = VW'(VOICES - 1);
        end else if (!phase_r) begin
          mreq.start = 1'b1; mreq.len = clamp(tlen_r);
          mreq.dividend = {6'd0, 32'(tick_r + 32'(toff_r))};
          phase_nxt = 1'b1;
        end else if (mdone) begin
          phase_nxt = 1'b0; st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (req_r == REQ_STEP || req_r == REQ_CLOCK || req_r == REQ_RELEASE ||
            sel_ok) st_nxt = ST_VOICE;
        else st_nxt = ST_IDLE;
        if (req_r == REQ_RELEASE && !trk_en) begin
          st_nxt = ST_NEXT; v_nxt = VW'(VOICES - 1);
        end
      end
      ST_VOICE: begin
        pch_nxt = 4'(32'(t_r) + TRACKS);
        pnote_nxt = m_note;
        case (req_r)
          REQ_STEP: begin
            if (!phase_r) begin
              mreq.start = 1'b1; mreq.len = clamp(m_len);
              mreq.dividend = {31'd0, 7'(pos_r + 7'(m_shift))};
              phase_nxt = 1'b1;
            end else if (mdone) begin
              phase_nxt = 1'b0; st_nxt = ST_NEXT;
              if (m_step[mrem[SW-1:0]]) begin
                pend_nxt = 1'b1; pkind_nxt = 1'b0;
                pvel_nxt = m_acc[mrem[SW-1:0]] ? avel_r : nvel_r;
                wr_en = 1'b1; wr_data = {m_step, m_acc, m_note, m_shift, m_len,
                                         {1'b0, gate_len_r}};
              end
            end
          end
          REQ_CLOCK: begin
            st_nxt = ST_NEXT;
            if (m_gate != GATE_IDLE) begin
              wr_en = 1'b1;
              wr_data = {m_step, m_acc, m_note, m_shift, m_len,
                         (m_gate == 8'd1) ? GATE_IDLE : 8'(m_gate - 8'd1)};
              if (m_gate == 8'd1) begin
                pend_nxt = 1'b1; pkind_nxt = 1'b1; pvel_nxt = '0;
              end
            end
          end
          REQ_RELEASE: begin
            st_nxt = ST_NEXT; pend_nxt = 1'b1; pkind_nxt = 1'b1; pvel_nxt = '0;
            wr_en = 1'b1;
            wr_data = {m_step, m_acc, m_note, m_shift, m_len, GATE_IDLE};
          end
          REQ_REST, REQ_ACCENT: begin
            st_nxt = ST_IDLE;
            if (32'(si_r) < STEPS) begin
              wr_en = 1'b1;
              wr_data = rd_r;
              if (req_r == REQ_REST) wr_data[MW-1-(STEPS-1-32'(si_r))] = !bv_r;
              else wr_data[MW-STEPS-1-(STEPS-1-32'(si_r))] = bv_r;
            end
          end
          REQ_NOTE: begin
            st_nxt = ST_IDLE; wr_en = 1'b1;
            wr_data = {m_step, m_acc, nv_r, m_shift, m_len, m_gate};
          end
          REQ_SHIFT: begin
            st_nxt = ST_IDLE; wr_en = 1'b1;
            wr_data = {m_step, m_acc, m_note, vo_r, vl_r, m_gate};
          end
          default: st_nxt = ST_IDLE;
        endcase
      end
      ST_NEXT: begin
        if (!lastv) begin
          v_nxt = v_r + VW'(1); st_nxt = ST_READ;
        end else if (!lastt) begin
          v_nxt = '0; t_nxt = t_r + TW'(1);
          st_nxt = (req_r == REQ_STEP) ? ST_POS : ST_READ;
        end else st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; clr_r <= '0; pend_r <= 1'b0; phase_r <= 1'b0;
      out_valid <= 1'b0; t_r <= '0; v_r <= '0;
    end else begin
      st_r <= st_nxt; t_r <= t_nxt; v_r <= v_nxt; phase_r <= phase_nxt;
      if (clearing) clr_r <= clr_r + (AW+1)'(1);
      // hold one word back so the final one can carry last
      if (pend_nxt) pend_r <= 1'b1;
      else if (st_r != ST_IDLE && st_nxt == ST_IDLE) pend_r <= 1'b0;
      out_valid <= pend_r && (pend_nxt || (st_r != ST_IDLE && st_nxt == ST_IDLE));
    end
    if (st_r == ST_POS && mdone) pos_r <= mrem;
    if (pend_nxt || (st_r != ST_IDLE && st_nxt == ST_IDLE)) begin
      out_event_kind <= pkind_r; out_note <= pnote_r; out_velocity <= pvel_r;
      out_channel <= pch_r; out_last <= !pend_nxt;
    end
    if (pend_nxt) begin
      pkind_r <= pkind_nxt; pnote_r <= pnote_nxt; pvel_r <= pvel_nxt;
      pch_r <= pch_nxt;
    end
  end

`ifndef SYNTH
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept without busy");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> st_r == ST_IDLE) else $error("work during sweep");
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && $past(st_r) == ST_IDLE) |-> !out_valid)
    else $error("word while idle");
`endif
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the drum step sequencer: directed and random requests.
`default_nettype none
module tb;
  import dss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTRK = 2;
  localparam int NVOC = 16;
  localparam int NSTP = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic       kind;
    logic [6:0] note;
    logic [6:0] vel;
    logic [3:0] chan;
    logic       last;
  } note_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_req_type = '0;
  logic [31:0] in_tick = '0;
  logic in_track_sel = 1'b0;
  logic in_all_tracks = 1'b0;
  logic [3:0] in_voice_sel = '0;
  logic [3:0] in_step_index = '0;
  logic in_bit_value = 1'b0;
  logic [6:0] in_note_value = '0;
  logic [3:0] in_voice_offset = '0;
  logic [4:0] in_voice_length = '0;
  logic out_valid, out_event_kind, out_last;
  logic [6:0] out_note, out_velocity;
  logic [3:0] out_channel;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  drum_step_sequencer dut (
    .clk, .rst_n, .start, .busy, .in_req_type, .in_tick, .in_track_sel,
    .in_all_tracks, .in_voice_sel, .in_step_index, .in_bit_value, .in_note_value,
    .in_voice_offset, .in_voice_length, .out_valid, .out_event_kind, .out_note,
    .out_velocity, .out_channel, .out_last, .psel, .penable, .pwrite, .paddr,
    .pwdata, .prdata, .pready
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [6:0] gate_len_r, nvel_r, avel_r;
  logic [4:0] tlen_r;
  logic [3:0] toff_r;
  logic [1:0] mute_r;
  logic [15:0] steps_m [NTRK][NVOC];
  logic [15:0] accents_m [NTRK][NVOC];
  logic [6:0] notes_m [NTRK][NVOC];
  logic [3:0] shifts_m [NTRK][NVOC];
  logic [4:0] lens_m [NTRK][NVOC];
  logic [7:0] gates_m [NTRK][NVOC];

  note_event_t pending_events[$];
  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int events_seen = 0;
  bit idle_ok = 1'b1;

  function automatic int eff_len(logic [4:0] len);
    if (len == 0) return 1;
    if (len > NSTP) return NSTP;
    return len;
  endfunction

  task automatic push_event(logic kind, logic [6:0] note, logic [6:0] vel, int t);
    note_event_t e;
    e.kind = kind;
    e.note = note;
    e.vel = vel;
    e.chan = 4'(t + NTRK);
    e.last = 1'b0;
    pending_events.push_back(e);
  endtask

  task automatic predict_events(logic [2:0] rq, logic [31:0] tk, logic ts, logic al,
                                logic [3:0] vs, logic [3:0] si, logic bv,
                                logic [6:0] nv, logic [3:0] vo, logic [4:0] vl);
    int n;
    int pos;
    int st;
    logic [31:0] sum;
    n = 0;
    case (rq)
      REQ_STEP: begin
        for (int t = 0; t < NTRK; t++) begin
          if (mute_r[t]) continue;
          sum = tk + 32'(toff_r);
          pos = int'(sum % 32'(eff_len(tlen_r)));
          for (int v = 0; v < NVOC; v++) begin
            st = (pos + shifts_m[t][v]) % eff_len(lens_m[t][v]);
            if (steps_m[t][v][st]) begin
              gates_m[t][v] = {1'b0, gate_len_r};
              push_event(1'b0, notes_m[t][v], accents_m[t][v][st] ? avel_r : nvel_r, t);
              n++;
            end
          end
        end
      end
      REQ_CLOCK: begin
        for (int t = 0; t < NTRK; t++)
          for (int v = 0; v < NVOC; v++)
            if (gates_m[t][v] != GATE_IDLE) begin
              gates_m[t][v] = gates_m[t][v] - 8'd1;
              if (gates_m[t][v] == 0) begin
                push_event(1'b1, notes_m[t][v], 7'd0, t);
                n++;
                gates_m[t][v] = GATE_IDLE;
              end
            end
      end
      REQ_REST: steps_m[ts][vs][si] = ~bv;
      REQ_ACCENT: accents_m[ts][vs][si] = bv;
      REQ_NOTE: notes_m[ts][vs] = nv;
      REQ_SHIFT: begin
        shifts_m[ts][vs] = vo;
        lens_m[ts][vs] = vl;
      end
      REQ_RELEASE: begin
        for (int t = 0; t < NTRK; t++) begin
          if (!al && t != ts) continue;
          for (int v = 0; v < NVOC; v++) begin
            push_event(1'b1, notes_m[t][v], 7'd0, t);
            n++;
            gates_m[t][v] = GATE_IDLE;
          end
        end
      end
      default: ;
    endcase
    if (n > 0) pending_events[$].last = 1'b1;
  endtask

  task automatic idle_gap();
    if (idle_ok && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 10)) @(posedge clk);
  endtask

  task automatic send_word(logic [2:0] rq, logic [31:0] tk, logic ts, logic al,
                           logic [3:0] vs, logic [3:0] si, logic bv,
                           logic [6:0] nv, logic [3:0] vo, logic [4:0] vl);
    idle_gap();
    start <= 1'b1;
    in_req_type <= rq;
    in_tick <= tk;
    in_track_sel <= ts;
    in_all_tracks <= al;
    in_voice_sel <= vs;
    in_step_index <= si;
    in_bit_value <= bv;
    in_note_value <= nv;
    in_voice_offset <= vo;
    in_voice_length <= vl;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_events(rq, tk, ts, al, vs, si, bv, nv, vo, vl);
    words_sent++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_simple(logic [2:0] rq, logic [31:0] tk);
    send_word(rq, tk, 1'($urandom), 1'($urandom), 4'($urandom), 4'($urandom),
              1'($urandom), 7'($urandom), 4'($urandom), 5'($urandom));
  endtask

  task automatic drain();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GATE: gate_len_r = val[6:0];
      REG_NVEL: nvel_r = val[6:0];
      REG_AVEL: avel_r = val[6:0];
      REG_TLEN: tlen_r = val[4:0];
      REG_TOFF: toff_r = val[3:0];
      REG_MUTE: mute_r = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [6:0] g, logic [6:0] nv, logic [6:0] av,
                            logic [4:0] tl, logic [3:0] to, logic [1:0] mm);
    drain();
    write_reg(REG_GATE, 32'(g));
    write_reg(REG_NVEL, 32'(nv));
    write_reg(REG_AVEL, 32'(av));
    write_reg(REG_TLEN, 32'(tl));
    write_reg(REG_TOFF, 32'(to));
    write_reg(REG_MUTE, 32'(mm));
  endtask

  task automatic test_directed();
    send_simple(REQ_STEP, 32'd0);
    send_simple(REQ_STEP, 32'd4);
    send_word(REQ_ACCENT, 0, 1'b0, 1'b0, 4'd0, 4'd8, 1'b1, 0, 0, 0);
    send_word(REQ_REST, 0, 1'b1, 1'b0, 4'd15, 4'd15, 1'b0, 0, 0, 0);
    send_word(REQ_NOTE, 0, 1'b1, 1'b0, 4'd15, 0, 0, 7'd127, 0, 0);
    send_word(REQ_NOTE, 0, 1'b0, 1'b0, 4'd0, 0, 0, 7'd0, 0, 0);
    send_word(REQ_SHIFT, 0, 1'b1, 1'b0, 4'd15, 0, 0, 0, 4'd15, 5'd0);
    send_simple(REQ_STEP, 32'd8);
    repeat (6) send_simple(REQ_CLOCK, 0);
    send_word(REQ_SHIFT, 0, 1'b0, 1'b0, 4'd0, 0, 0, 0, 4'd3, 5'd31);
    send_simple(REQ_STEP, 32'hFFFF_FFFF);
    send_simple(REQ_STEP, 32'd1);
    send_word(REQ_RELEASE, 0, 1'b1, 1'b0, 0, 0, 0, 0, 0, 0);
    send_word(REQ_RELEASE, 0, 1'b0, 1'b1, 0, 0, 0, 0, 0, 0);
    send_simple(REQ_UNUSED, 32'($urandom));
  endtask

  task automatic test_config_extremes();
    set_config(7'd0, 7'd0, 7'd127, 5'd0, 4'd15, 2'd1);
    send_simple(REQ_STEP, 32'hFFFF_FFF3);
    repeat (2) send_simple(REQ_CLOCK, 0);
    set_config(7'd127, 7'd127, 7'd0, 5'd31, 4'd0, 2'd2);
    send_simple(REQ_STEP, 32'd12);
    send_simple(REQ_CLOCK, 0);
    set_config(7'd1, 7'd64, 7'd90, 5'd7, 4'd5, 2'd3);
    send_simple(REQ_STEP, 32'd3);
    set_config(7'd2, 7'd100, 7'd127, 5'd16, 4'd0, 2'd0);
  endtask

  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      if (i > count * 3 / 4) idle_ok = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 30) send_simple(REQ_STEP, 32'($urandom));
      else if (r < 55) send_simple(REQ_CLOCK, 0);
      else if (r < 70) send_simple(REQ_REST, 0);
      else if (r < 80) send_simple(REQ_ACCENT, 0);
      else if (r < 86) send_simple(REQ_NOTE, 0);
      else if (r < 93) send_simple(REQ_SHIFT, 0);
      else if (r < 97) send_simple(REQ_RELEASE, 0);
      else send_simple(REQ_UNUSED, 0);
    end
  endtask

  always @(posedge clk) begin
    note_event_t exp_ev;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_valid) begin
      events_seen <= events_seen + 1;
      if (pending_events.size() == 0) begin
        $error("unexpected event note=%0d", out_note);
        errors++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_event_kind !== exp_ev.kind) begin
          $error("event_kind exp %0d got %0d", exp_ev.kind, out_event_kind);
          errors++;
        end
        if (out_note !== exp_ev.note) begin
          $error("note exp %0d got %0d", exp_ev.note, out_note);
          errors++;
        end
        if (out_velocity !== exp_ev.vel) begin
          $error("velocity exp %0d got %0d", exp_ev.vel, out_velocity);
          errors++;
        end
        if (out_channel !== exp_ev.chan) begin
          $error("channel exp %0d got %0d", exp_ev.chan, out_channel);
          errors++;
        end
        if (out_last !== exp_ev.last) begin
          $error("last exp %0d got %0d", exp_ev.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    gate_len_r = 7'd5;
    nvel_r = 7'd100;
    avel_r = 7'd127;
    tlen_r = 5'd16;
    toff_r = 4'd0;
    mute_r = 2'd0;
    for (int t = 0; t < NTRK; t++)
      for (int v = 0; v < NVOC; v++) begin
        steps_m[t][v] = (v == 0) ? 16'h1111 : 16'h0;
        accents_m[t][v] = '0;
        notes_m[t][v] = 7'(NOTE_BASE + v);
        shifts_m[t][v] = '0;
        lens_m[t][v] = 5'(NSTP);
        gates_m[t][v] = GATE_IDLE;
      end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random(84);
    drain();
    $display("Sent %0d request words, checked %0d note events", words_sent, events_seen);
    $display("Covered step and clock ticks, edits, releases and register extremes");
    if (errors == 0 && pending_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
